/* hw/rtl/flbc_pkg.sv */
// Shared types, register codes and twiddle table function for the block compressor.
`default_nettype none

package flbc_pkg;

    localparam int MAX_POINTS_DEF     = 1024;
    localparam int COMPONENT_BITS_DEF = 32;

    localparam int SIZE_W = 4;
    localparam int KEEP_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST  = 4'd10;
    localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Divisors of the nested Taylor terms for sine and cosine.
    localparam longint SIN_DIV_0 = Q30_ONE * 64'sd110;
    localparam longint SIN_DIV_1 = Q30_ONE * 64'sd72;
    localparam longint SIN_DIV_2 = Q30_ONE * 64'sd42;
    localparam longint SIN_DIV_3 = Q30_ONE * 64'sd20;
    localparam longint SIN_DIV_4 = Q30_ONE * 64'sd6;
    localparam longint COS_DIV_0 = Q30_ONE * 64'sd132;
    localparam longint COS_DIV_1 = Q30_ONE * 64'sd90;
    localparam longint COS_DIV_2 = Q30_ONE * 64'sd56;
    localparam longint COS_DIV_3 = Q30_ONE * 64'sd30;
    localparam longint COS_DIV_4 = Q30_ONE * 64'sd12;
    localparam longint COS_DIV_5 = Q30_ONE * 64'sd2;

    typedef enum logic [2:0] {
        WS_LOAD,
        WS_ZERO,
        WS_SWAP_I,
        WS_SWAP_J,
        WS_BF_A,
        WS_BF_B
    } t_wsel;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        t_wsel wr_sel;
        logic  inverse;
        logic  out_load;
        logic  out_final;
    } t_ctl;

    function automatic longint to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r < 0) r = 0;
        if (r > 32768) r = 32768;
        return r;
    endfunction

    // Returns {cos, sin} in 17-bit Q15 for the angle 2*pi*t/2^mlog.
    function automatic logic [33:0] tw_entry(input int t, input int mlog);
        longint ph;
        longint quad;
        longint frac;
        longint x;
        longint x2;
        longint ts;
        longint tc;
        longint sv;
        longint cv;
        longint c;
        longint s;
        ph = (longint'(t) << (32 - mlog)) & 64'sh0000_0000_FFFF_FFFF;
        quad = (ph >> 30) & 64'sd3;
        frac = ph & 64'sh0000_0000_3FFF_FFFF;
        x = (frac * HALF_PI_Q30) >> 30;
        x2 = (x * x) / Q30_ONE;
        ts = Q30_ONE;
        tc = Q30_ONE;
        ts = Q30_ONE - (x2 * ts) / SIN_DIV_0;
        ts = Q30_ONE - (x2 * ts) / SIN_DIV_1;
        ts = Q30_ONE - (x2 * ts) / SIN_DIV_2;
        ts = Q30_ONE - (x2 * ts) / SIN_DIV_3;
        ts = Q30_ONE - (x2 * ts) / SIN_DIV_4;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_0;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_1;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_2;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_3;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_4;
        tc = Q30_ONE - (x2 * tc) / COS_DIV_5;
        sv = to_q15((x * ts) / Q30_ONE);
        cv = to_q15(tc);
        case (quad)
            64'sd0: begin c = cv; s = sv; end
            64'sd1: begin c = -sv; s = cv; end
            64'sd2: begin c = -cv; s = -sv; end
            default: begin c = sv; s = -cv; end
        endcase
        return {c[16:0], s[16:0]};
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fft_lowpass_block_compressor_core.sv */
// Top level: a load is accepted while idle; the load marked last starts the work
// (zero padding, bit-reversal swaps, forward passes, bin clearing, bit-reversal
// and inverse passes), one butterfly at a time through the single write port.
// A read's item is registered in the result register via S_RD_OUT; no input is
// taken while it waits. Reset restores the registers to 10 and 1024 and empties
// the block; memory is zero padded.
`default_nettype none

module fft_lowpass_block_compressor_core #(
    parameter int MAX_POINTS     = flbc_pkg::MAX_POINTS_DEF,
    parameter int COMPONENT_BITS = flbc_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_opcode,
    input  wire logic signed [7:0]                i_sample,
    input  wire logic                             i_last,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [7:0]                     o_value,
    output logic                                  o_final_res,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [flbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [flbc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);

    flbc_pkg::t_ctl w_ctl;
    logic [AW-1:0]  w_rd_a, w_rd_b, w_wr_addr, w_tw_idx;
    logic           w_out_busy;

    flbc_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_opcode   (i_opcode),
        .i_last     (i_last),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_out_busy (w_out_busy),
        .o_ctl      (w_ctl),
        .o_rd_a     (w_rd_a),
        .o_rd_b     (w_rd_b),
        .o_wr_addr  (w_wr_addr),
        .o_tw_idx   (w_tw_idx)
    );

    flbc_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_a     (w_rd_a),
        .i_rd_b     (w_rd_b),
        .i_wr_addr  (w_wr_addr),
        .i_tw_idx   (w_tw_idx),
        .i_sample   (i_sample),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_final_res(o_final_res),
        .o_out_busy (w_out_busy)
    );

endmodule

`default_nettype wire

/* hw/rtl/flbc_ctrl.sv */
// Sequencer for loading, padding, transform passes, bin clearing and readout.
`default_nettype none

module flbc_ctrl #(
    parameter int MAX_POINTS = flbc_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_opcode,
    input  wire logic                             i_last,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [flbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [flbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                             i_out_busy,
    output flbc_pkg::t_ctl                        o_ctl,
    output logic [$clog2(MAX_POINTS)-1:0]         o_rd_a,
    output logic [$clog2(MAX_POINTS)-1:0]         o_rd_b,
    output logic [$clog2(MAX_POINTS)-1:0]         o_wr_addr,
    output logic [$clog2(MAX_POINTS)-1:0]         o_tw_idx
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LW = $clog2(AW + 1);
    localparam int CW = (AW + 1 > flbc_pkg::KEEP_W) ? AW + 1 : flbc_pkg::KEEP_W;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RD_OUT = 13'b0000000000010,
        S_PAD    = 13'b0000000000100,
        S_REV    = 13'b0000000001000,
        S_REV_WI = 13'b0000000010000,
        S_REV_WJ = 13'b0000000100000,
        S_BF_RD  = 13'b0000001000000,
        S_BF_MUL = 13'b0000010000000,
        S_BF_TW  = 13'b0000100000000,
        S_BF_SUM = 13'b0001000000000,
        S_BF_WA  = 13'b0010000000000,
        S_BF_WB  = 13'b0100000000000,
        S_CLR    = 13'b1000000000000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_phase_rd, n_phase_rd;
    logic [AW:0]                   r_lc, n_lc;
    logic [AW-1:0]                 r_rp, n_rp;
    logic [AW-1:0]                 r_k, n_k;
    logic [AW-1:0]                 r_b, n_b;
    logic [LW-1:0]                 r_stage, n_stage;
    logic                          r_inv, n_inv;
    logic                          r_fin, n_fin;
    logic [flbc_pkg::SIZE_W-1:0]   r_size;
    logic [flbc_pkg::KEEP_W-1:0]   r_keep;

    logic [LW-1:0]  w_lg;
    logic [AW:0]    w_n;
    logic [AW-1:0]  w_nm1;
    logic [AW-1:0]  w_halfm1;
    logic [AW-1:0]  w_rev_full;
    logic [AW-1:0]  w_rev;
    logic [LW-1:0]  w_sm1;
    logic [AW-1:0]  w_hm;
    logic [AW-1:0]  w_pos;
    logic [AW-1:0]  w_a;
    logic [AW-1:0]  w_bi;
    logic [CW-1:0]  w_thr;
    logic           w_zero_hit;
    logic           w_acc;
    logic           w_step_done;
    logic           w_pass_done;

    assign w_lg     = (32'(r_size) > AW) ? LW'(AW) : LW'(r_size);
    assign w_n      = (AW + 1)'(1) << w_lg;
    assign w_nm1    = AW'(w_n - (AW + 1)'(1));
    assign w_halfm1 = AW'((w_n >> 1) - (AW + 1)'(1));

    always_comb begin
        for (int i = 0; i < AW; i++) begin
            w_rev_full[i] = r_k[AW-1-i];
        end
    end
    assign w_rev = w_rev_full >> (LW'(AW) - w_lg);

    assign w_sm1 = r_stage - LW'(1);
    assign w_hm  = (AW'(1) << w_sm1) - AW'(1);
    assign w_pos = r_b & w_hm;
    assign w_a   = ((r_b >> w_sm1) << r_stage) | w_pos;
    assign w_bi  = w_a | (AW'(1) << w_sm1);

    assign w_thr      = (r_state == S_PAD) ? CW'(r_lc) : CW'(r_keep);
    assign w_zero_hit = CW'(r_k) >= w_thr;

    assign o_ready     = (r_state == S_IDLE) && !i_out_busy;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= flbc_pkg::SIZE_LOG2_RST;
            r_keep <= flbc_pkg::KEEP_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                flbc_pkg::CFG_SIZE_LOG2:  r_size <= i_cfg_data[flbc_pkg::SIZE_W-1:0];
                flbc_pkg::CFG_KEEP_COUNT: r_keep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_ctl.rd_en     = 1'b0;
        o_ctl.wr_en     = 1'b0;
        o_ctl.wr_sel    = flbc_pkg::WS_ZERO;
        o_ctl.inverse   = r_inv;
        o_ctl.out_load  = 1'b0;
        o_ctl.out_final = r_fin;
        o_rd_a          = r_k;
        o_rd_b          = w_rev;
        o_wr_addr       = r_k;
        o_tw_idx        = w_pos << (LW'(AW) - r_stage);
        unique case (r_state)
            S_IDLE: begin
                o_ctl.rd_en = 1'b1;
                o_rd_a      = r_rp;
                o_wr_addr   = r_lc[AW-1:0];
                if (w_acc && i_opcode == flbc_pkg::OP_LOAD && !r_phase_rd && r_lc < w_n) begin
                    o_ctl.wr_en  = 1'b1;
                    o_ctl.wr_sel = flbc_pkg::WS_LOAD;
                end
            end
            S_RD_OUT: o_ctl.out_load = 1'b1;
            S_PAD, S_CLR: o_ctl.wr_en = w_zero_hit;
            S_REV: o_ctl.rd_en = 1'b1;
            S_REV_WI: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = flbc_pkg::WS_SWAP_I;
            end
            S_REV_WJ: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = flbc_pkg::WS_SWAP_J;
                o_wr_addr    = w_rev;
            end
            S_BF_RD: begin
                o_ctl.rd_en = 1'b1;
                o_rd_a      = w_a;
                o_rd_b      = w_bi;
            end
            S_BF_WA: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = flbc_pkg::WS_BF_A;
                o_wr_addr    = w_a;
            end
            S_BF_WB: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_sel = flbc_pkg::WS_BF_B;
                o_wr_addr    = w_bi;
            end
            S_BF_MUL, S_BF_TW, S_BF_SUM: ;
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase_rd  = r_phase_rd;
        n_lc        = r_lc;
        n_rp        = r_rp;
        n_k         = r_k;
        n_b         = r_b;
        n_stage     = r_stage;
        n_inv       = r_inv;
        n_fin       = r_fin;
        w_step_done = 1'b0;
        w_pass_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_opcode == flbc_pkg::OP_LOAD) begin
                        if (!r_phase_rd) begin
                            if (r_lc < w_n) begin
                                n_lc = r_lc + (AW + 1)'(1);
                            end
                            if (i_last) begin
                                n_state = S_PAD;
                                n_k     = '0;
                            end
                        end
                    end else if (r_phase_rd) begin
                        n_state = S_RD_OUT;
                        n_fin   = ((AW + 1)'(r_rp) + (AW + 1)'(1)) >= r_lc;
                        if (((AW + 1)'(r_rp) + (AW + 1)'(1)) >= r_lc) begin
                            n_lc       = '0;
                            n_rp       = '0;
                            n_phase_rd = 1'b0;
                        end else begin
                            n_rp = r_rp + AW'(1);
                        end
                    end
                end
            end
            S_RD_OUT: n_state = S_IDLE;
            S_PAD: begin
                if (r_k == w_nm1) begin
                    n_k     = '0;
                    n_inv   = 1'b0;
                    n_state = S_REV;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            S_REV: begin
                if (w_rev > r_k) begin
                    n_state = S_REV_WI;
                end else begin
                    w_step_done = 1'b1;
                end
            end
            S_REV_WI: n_state = S_REV_WJ;
            S_REV_WJ: w_step_done = 1'b1;
            S_BF_RD:  n_state = S_BF_MUL;
            S_BF_MUL: n_state = S_BF_TW;
            S_BF_TW:  n_state = S_BF_SUM;
            S_BF_SUM: n_state = S_BF_WA;
            S_BF_WA:  n_state = S_BF_WB;
            S_BF_WB: begin
                n_state = S_BF_RD;
                if (r_b == w_halfm1) begin
                    n_b = '0;
                    if (r_stage == w_lg) begin
                        w_pass_done = 1'b1;
                    end else begin
                        n_stage = r_stage + LW'(1);
                    end
                end else begin
                    n_b = r_b + AW'(1);
                end
            end
            S_CLR: begin
                if (r_k == w_nm1) begin
                    n_k     = '0;
                    n_inv   = 1'b1;
                    n_state = S_REV;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_step_done) begin
            if (r_k == w_nm1) begin
                if (w_lg == '0) begin
                    w_pass_done = 1'b1;
                end else begin
                    n_stage = LW'(1);
                    n_b     = '0;
                    n_state = S_BF_RD;
                end
            end else begin
                n_k     = r_k + AW'(1);
                n_state = S_REV;
            end
        end

        if (w_pass_done) begin
            if (!r_inv) begin
                n_k     = '0;
                n_state = S_CLR;
            end else begin
                n_phase_rd = 1'b1;
                n_rp       = '0;
                n_state    = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase_rd <= 1'b0;
            r_lc       <= '0;
            r_rp       <= '0;
            r_k        <= '0;
            r_b        <= '0;
            r_stage    <= '0;
            r_inv      <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase_rd <= n_phase_rd;
            r_lc       <= n_lc;
            r_rp       <= n_rp;
            r_k        <= n_k;
            r_b        <= n_b;
            r_stage    <= n_stage;
            r_inv      <= n_inv;
            r_fin      <= n_fin;
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register is not one-hot");

    a_rp_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase_rd |-> ((AW + 1)'(r_rp) < r_lc))
        else $error("read pointer ran past the loaded count");

    a_no_load_when_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.wr_en && o_ctl.wr_sel == flbc_pkg::WS_LOAD) |-> !r_phase_rd)
        else $error("sample written while results are pending");

    a_bf_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BF_WA |=> r_state == S_BF_WB)
        else $error("butterfly wrote only one of its two points");

endmodule

`default_nettype wire

/* hw/rtl/flbc_datapath.sv */
// Working memory, twiddle table, butterfly arithmetic and result register.
`default_nettype none

module flbc_datapath #(
    parameter int MAX_POINTS     = flbc_pkg::MAX_POINTS_DEF,
    parameter int COMPONENT_BITS = flbc_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire flbc_pkg::t_ctl               i_ctl,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_rd_a,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_rd_b,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_tw_idx,
    input  wire logic signed [7:0]            i_sample,
    input  wire logic                         i_ready,
    output logic                              o_valid,
    output logic signed [7:0]                 o_value,
    output logic                              o_final_res,
    output logic                              o_out_busy
);

    localparam int W  = COMPONENT_BITS;
    localparam int PW = W + 17;
    localparam int TWW = PW - 14;

    logic signed [W-1:0] r_mem_re [MAX_POINTS];
    logic signed [W-1:0] r_mem_im [MAX_POINTS];
    logic [33:0]         w_rom [MAX_POINTS];

    logic signed [W-1:0] r_da_re, r_da_im, r_db_re, r_db_im;
    logic [33:0]         r_tw;
    logic signed [W-1:0] w_wd_re, w_wd_im;

    logic signed [16:0]  w_c, w_s0, w_s;
    logic signed [PW-1:0] r_p_cr, r_p_si, r_p_ci, r_p_sr;
    logic signed [PW:0]   w_pr, w_pi;
    logic signed [TWW-1:0] r_tr, r_ti;
    logic signed [W+3:0]  w_ar, w_ai, w_br, w_bi;
    logic signed [W-1:0]  r_ar, r_ai, r_br, r_bi;

    logic signed [W:0]    w_qs;
    logic signed [W-8:0]  w_q;
    logic signed [7:0]    w_q8;
    logic                 r_ovalid;
    logic signed [7:0]    r_value;
    logic                 r_final;

    function automatic logic signed [W-1:0] sat_comp(input logic signed [W+3:0] v,
                                                     input logic halve);
        logic signed [W+3:0] hi;
        logic signed [W+3:0] lo;
        logic signed [W+3:0] h;
        hi = (W + 4)'({1'b0, {(W - 1){1'b1}}});
        lo = -hi - (W + 4)'(1);
        h  = halve ? (v >>> 1) : v;
        if (h > hi) return hi[W-1:0];
        if (h < lo) return lo[W-1:0];
        return h[W-1:0];
    endfunction

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_rom
        assign w_rom[g] = flbc_pkg::tw_entry(g, $clog2(MAX_POINTS));
    end

    always_comb begin
        case (i_ctl.wr_sel)
            flbc_pkg::WS_LOAD: begin
                w_wd_re = W'(i_sample) <<< 8;
                w_wd_im = '0;
            end
            flbc_pkg::WS_SWAP_I: begin
                w_wd_re = r_db_re;
                w_wd_im = r_db_im;
            end
            flbc_pkg::WS_SWAP_J: begin
                w_wd_re = r_da_re;
                w_wd_im = r_da_im;
            end
            flbc_pkg::WS_BF_A: begin
                w_wd_re = r_ar;
                w_wd_im = r_ai;
            end
            flbc_pkg::WS_BF_B: begin
                w_wd_re = r_br;
                w_wd_im = r_bi;
            end
            default: begin
                w_wd_re = '0;
                w_wd_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem_re[i_wr_addr] <= w_wd_re;
            r_mem_im[i_wr_addr] <= w_wd_im;
        end
        if (i_ctl.rd_en) begin
            r_da_re <= r_mem_re[i_rd_a];
            r_da_im <= r_mem_im[i_rd_a];
            r_db_re <= r_mem_re[i_rd_b];
            r_db_im <= r_mem_im[i_rd_b];
            r_tw    <= w_rom[i_tw_idx];
        end
    end

    assign w_c  = signed'(r_tw[33:17]);
    assign w_s0 = signed'(r_tw[16:0]);
    assign w_s  = i_ctl.inverse ? -w_s0 : w_s0;

    assign w_pr = (PW + 1)'(r_p_cr) - (PW + 1)'(r_p_si) + (PW + 1)'(16384);
    assign w_pi = (PW + 1)'(r_p_ci) + (PW + 1)'(r_p_sr) + (PW + 1)'(16384);

    assign w_ar = (W + 4)'(r_da_re) + (W + 4)'(r_tr);
    assign w_ai = (W + 4)'(r_da_im) + (W + 4)'(r_ti);
    assign w_br = (W + 4)'(r_da_re) - (W + 4)'(r_tr);
    assign w_bi = (W + 4)'(r_da_im) - (W + 4)'(r_ti);

    always_ff @(posedge i_clk) begin
        r_p_cr <= PW'(w_c) * PW'(r_db_re);
        r_p_si <= PW'(w_s) * PW'(r_db_im);
        r_p_ci <= PW'(w_c) * PW'(r_db_im);
        r_p_sr <= PW'(w_s) * PW'(r_db_re);
        r_tr   <= w_pr[PW:15];
        r_ti   <= w_pi[PW:15];
        r_ar   <= sat_comp(w_ar, i_ctl.inverse);
        r_ai   <= sat_comp(w_ai, i_ctl.inverse);
        r_br   <= sat_comp(w_br, i_ctl.inverse);
        r_bi   <= sat_comp(w_bi, i_ctl.inverse);
    end

    assign w_qs = r_da_re[W-1] ? (W + 1)'(r_da_re) + (W + 1)'(255) : (W + 1)'(r_da_re);
    assign w_q  = w_qs[W:8];
    assign w_q8 = (w_q > (W - 7)'(127))  ? 8'sd127 :
                  (w_q < -(W - 7)'(128)) ? -8'sd128 : w_q[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_ctl.out_load) begin
            r_value <= w_q8;
            r_final <= i_ctl.out_final;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_value     = r_value;
    assign o_final_res = r_final;
    assign o_out_busy  = r_ovalid;

endmodule

`default_nettype wire

/* tb/fft_lowpass_block_compressor_core_tb.sv */
// Self-checking testbench for the FFT low-pass block compressor core.
`default_nettype none

module fft_lowpass_block_compressor_core_tb;

    localparam logic [flbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [flbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int LOG_MAX = 10;
    localparam int N_MAX = 1 << LOG_MAX;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_opcode = flbc_pkg::OP_LOAD;
    logic signed [7:0] i_sample = '0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [7:0] o_value;
    logic o_final_res;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [flbc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [flbc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fft_lowpass_block_compressor_core dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct {
        logic signed [7:0] value;
        logic fin;
    } t_sample_out;

    class compressor_scoreboard;
        longint re[N_MAX];
        longint im[N_MAX];
        longint cos_q15[N_MAX];
        longint sin_q15[N_MAX];
        int unsigned loaded;
        int unsigned rd_ptr;
        bit reading;
        int unsigned size_reg;
        int unsigned keep_reg;
        t_sample_out pending[$];
        int errors;

        function new();
            for (int t = 0; t < N_MAX; t++) build_twiddle(t);
            size_reg = 10;
            keep_reg = 1024;
            errors = 0;
            clear_block();
        endfunction

        function longint round_q15(longint v);
            longint r;
            r = (v + 64'sd16384) >>> 15;
            if (r < 0) r = 0;
            if (r > 32768) r = 32768;
            return r;
        endfunction

        function void build_twiddle(int t);
            longint sdiv[5];
            longint cdiv[6];
            longint one;
            longint ph;
            longint x;
            longint x2;
            longint ts;
            longint tc;
            longint sv;
            longint cv;
            sdiv = '{110, 72, 42, 20, 6};
            cdiv = '{132, 90, 56, 30, 12, 2};
            one = 64'sd1 << 30;
            ph = (longint'(t) << (32 - LOG_MAX)) & 64'shFFFF_FFFF;
            x = ((ph & 64'sh3FFF_FFFF) * 64'sd1686629713) >>> 30;
            x2 = (x * x) / one;
            ts = one;
            tc = one;
            for (int i = 0; i < 5; i++) ts = one - (x2 * ts) / (one * sdiv[i]);
            for (int i = 0; i < 6; i++) tc = one - (x2 * tc) / (one * cdiv[i]);
            sv = round_q15((x * ts) / one);
            cv = round_q15(tc);
            case ((ph >> 30) & 3)
                0: begin cos_q15[t] = cv; sin_q15[t] = sv; end
                1: begin cos_q15[t] = -sv; sin_q15[t] = cv; end
                2: begin cos_q15[t] = -cv; sin_q15[t] = -sv; end
                default: begin cos_q15[t] = sv; sin_q15[t] = -cv; end
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void clear_block();
            for (int i = 0; i < N_MAX; i++) begin
                re[i] = 0;
                im[i] = 0;
            end
            loaded = 0;
            rd_ptr = 0;
            reading = 0;
        endfunction

        function void transform(int unsigned n, int lg, bit inv);
            int unsigned j;
            int unsigned a;
            int unsigned b;
            longint tmp;
            longint c;
            longint s;
            longint tr;
            longint ti;
            longint ar;
            longint ai;
            longint br;
            longint bi;
            for (int unsigned i = 0; i < n; i++) begin
                j = 0;
                for (int m = 0; m < lg; m++) j |= ((i >> m) & 1) << (lg - 1 - m);
                if (j > i) begin
                    tmp = re[i]; re[i] = re[j]; re[j] = tmp;
                    tmp = im[i]; im[i] = im[j]; im[j] = tmp;
                end
            end
            for (int unsigned m = 2; m <= n; m <<= 1) begin
                for (int unsigned base = 0; base < n; base += m) begin
                    for (int unsigned i = 0; i < m / 2; i++) begin
                        a = base + i;
                        b = a + m / 2;
                        c = cos_q15[i * (N_MAX / m)];
                        s = sin_q15[i * (N_MAX / m)];
                        if (inv) s = -s;
                        tr = (c * re[b] - s * im[b] + 64'sd16384) >>> 15;
                        ti = (c * im[b] + s * re[b] + 64'sd16384) >>> 15;
                        ar = re[a] + tr; ai = im[a] + ti;
                        br = re[a] - tr; bi = im[a] - ti;
                        if (inv) begin
                            ar = ar >>> 1; ai = ai >>> 1;
                            br = br >>> 1; bi = bi >>> 1;
                        end
                        re[a] = sat32(ar); im[a] = sat32(ai);
                        re[b] = sat32(br); im[b] = sat32(bi);
                    end
                end
            end
        endfunction

        function void configure(logic [flbc_pkg::CFG_IDX_W-1:0] idx,
                                logic [flbc_pkg::CFG_DATA_W-1:0] data);
            if (idx == flbc_pkg::CFG_SIZE_LOG2) size_reg = data[flbc_pkg::SIZE_W-1:0];
            else if (idx == flbc_pkg::CFG_KEEP_COUNT) keep_reg = data[flbc_pkg::KEEP_W-1:0];
        endfunction

        function void note_input(logic op, logic signed [7:0] smp, logic last);
            int lg;
            int unsigned n;
            longint q;
            t_sample_out r;
            if (op == flbc_pkg::OP_LOAD) begin
                if (reading) return;
                lg = (size_reg > LOG_MAX) ? LOG_MAX : size_reg;
                n = 1 << lg;
                if (loaded < n) begin
                    re[loaded] = longint'(smp) * 256;
                    im[loaded] = 0;
                    loaded++;
                end
                if (last) begin
                    transform(n, lg, 0);
                    for (int unsigned k = keep_reg; k < n; k++) begin
                        re[k] = 0;
                        im[k] = 0;
                    end
                    transform(n, lg, 1);
                    rd_ptr = 0;
                    reading = 1;
                end
            end else begin
                if (!reading) return;
                q = re[rd_ptr] / 256;
                if (q > 127) q = 127;
                if (q < -128) q = -128;
                r.value = q[7:0];
                r.fin = (rd_ptr + 1 >= loaded);
                pending.push_back(r);
                if (r.fin) clear_block();
                else rd_ptr++;
            end
        endfunction

        function void check_result(logic signed [7:0] value, logic fin);
            t_sample_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value %0d final %0b", $time, value, fin);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (value !== e.value) begin
                $display("%0t: value expected %0d actual %0d", $time, e.value, value);
                errors++;
            end
            if (fin !== e.fin) begin
                $display("%0t: final_res expected %0b actual %0b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    compressor_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int items_sent = 0;
    int cur_size = 10;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.configure(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) sb.note_input(i_opcode, i_sample, i_last);
            if (o_valid && i_ready) sb.check_result(o_value, o_final_res);
        end
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_cnt <= 400;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic op, logic signed [7:0] smp, logic last);
        i_valid <= 1'b1;
        i_opcode <= op;
        i_sample <= smp;
        i_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [flbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [flbc_pkg::CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == flbc_pkg::CFG_SIZE_LOG2)
            cur_size = (data[3:0] > LOG_MAX) ? LOG_MAX : data[3:0];
    endtask

    task automatic random_block(int n_loads, bit noisy);
        int n_reads;
        n_reads = (n_loads < (1 << cur_size)) ? n_loads : (1 << cur_size);
        for (int i = 0; i < n_loads; i++) begin
            if (noisy && $urandom_range(9) == 0)
                send_item(flbc_pkg::OP_READ, $urandom_range(255), $urandom_range(1));
            send_item(flbc_pkg::OP_LOAD, $urandom_range(255), i == n_loads - 1);
        end
        for (int i = 0; i < n_reads; i++) begin
            if (noisy && $urandom_range(9) == 0)
                send_item(flbc_pkg::OP_LOAD, $urandom_range(255), $urandom_range(1));
            send_item(flbc_pkg::OP_READ, $urandom_range(255), $urandom_range(1));
        end
    endtask

    initial begin
        int blk;
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: full-length transform, nothing cleared.
        send_item(flbc_pkg::OP_READ, 8'sd5, 1'b1);
        send_item(flbc_pkg::OP_LOAD, 8'sd127, 1'b0);
        send_item(flbc_pkg::OP_LOAD, -8'sd128, 1'b0);
        send_item(flbc_pkg::OP_LOAD, 8'sd0, 1'b1);
        send_item(flbc_pkg::OP_LOAD, 8'sd77, 1'b1);
        repeat (3) send_item(flbc_pkg::OP_READ, 8'sd0, 1'b0);

        // Single point with every bin cleared.
        write_reg(flbc_pkg::CFG_SIZE_LOG2, 11'd0);
        write_reg(flbc_pkg::CFG_KEEP_COUNT, 11'd0);
        send_item(flbc_pkg::OP_LOAD, -8'sd1, 1'b1);
        send_item(flbc_pkg::OP_READ, -8'sd1, 1'b1);

        // Block overflow with a keep count beyond the transform length.
        write_reg(flbc_pkg::CFG_SIZE_LOG2, 11'd2);
        write_reg(flbc_pkg::CFG_KEEP_COUNT, 11'd2047);
        for (int i = 0; i < 6; i++)
            send_item(flbc_pkg::OP_LOAD, (i & 1) ? -8'sd128 : 8'sd127, i == 5);
        repeat (4) send_item(flbc_pkg::OP_READ, 8'sd0, 1'b0);

        // Oversized size register saturates to the largest transform.
        write_reg(flbc_pkg::CFG_SIZE_LOG2, 11'd15);
        write_reg(flbc_pkg::CFG_KEEP_COUNT, 11'd1);
        send_item(flbc_pkg::OP_LOAD, 8'sd100, 1'b0);
        send_item(flbc_pkg::OP_LOAD, -8'sd100, 1'b1);
        repeat (2) send_item(flbc_pkg::OP_READ, 8'sd0, 1'b0);

        write_reg(CFG_SPARE_A, 11'h7FF);
        write_reg(CFG_SPARE_B, 11'h555);
        write_reg(flbc_pkg::CFG_SIZE_LOG2, 11'd3);
        write_reg(flbc_pkg::CFG_KEEP_COUNT, 11'd3);
        random_block(8, 0);

        blk = 0;
        while (items_sent < 1150) begin
            case (blk % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 75; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 75; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            if ($urandom_range(3) == 0)
                write_reg(flbc_pkg::CFG_SIZE_LOG2, ($urandom_range(9) == 0) ?
                          $urandom_range(6, 15) : $urandom_range(0, 5));
            n = 1 << cur_size;
            if ($urandom_range(2) == 0)
                write_reg(flbc_pkg::CFG_KEEP_COUNT, ($urandom_range(4) == 0) ?
                          $urandom_range(2047) : $urandom_range(0, n + 1));
            if (blk == 9) begin
                send_idle_pct = 0;
                hold_req = 1;
            end
            random_block((n > 64) ? $urandom_range(1, 40) : $urandom_range(1, n + 2),
                         $urandom_range(1));
            blk++;
        end
        send_idle_pct = 0;
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
